[design/bqd_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and command encodings for the biquad IIR filter.
package bqd_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_BITS      = 32;
	localparam int COEF_FRAC_BITS = 28;
	localparam int GUARD_BITS     = 16;
	localparam int ACC_BITS       = 48;
	localparam int CHUNK_BITS     = ACC_BITS / 2;
	localparam int PROD_BITS      = COEF_BITS + CHUNK_BITS;
	localparam int WIDE_BITS      = COEF_BITS + ACC_BITS;
	localparam int SUM_BITS       = ACC_BITS + 2;
	localparam int DATA_BITS      = 32;
	localparam int ADDR_BITS      = 5;

	localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;
	localparam logic [ACC_BITS-1:0]  ACC_MAX  = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic [ACC_BITS-1:0]  ACC_MIN  = {1'b1, {(ACC_BITS-1){1'b0}}};
	localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_B0     = 3'd0,
		REG_B1     = 3'd1,
		REG_B2     = 3'd2,
		REG_A1     = 3'd3,
		REG_A2     = 3'd4,
		REG_BYPASS = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] b0;
		logic signed [COEF_BITS-1:0] b1;
		logic signed [COEF_BITS-1:0] b2;
		logic signed [COEF_BITS-1:0] a1;
		logic signed [COEF_BITS-1:0] a2;
		logic                        bypass;
	} cfg_t;

	typedef enum logic [2:0] {CS_B0, CS_B1, CS_B2, CS_A1, CS_A2} coef_sel_t;
	typedef enum logic [1:0] {OP_X, OP_YLO, OP_YHI} opnd_sel_t;
	typedef enum logic [1:0] {BS_ZERO, BS_S1, BS_S2, BS_SUM} base_sel_t;
	typedef enum logic [1:0] {DST_SUM, DST_Y, DST_S1, DST_S2} dst_sel_t;

	typedef struct packed {
		logic      load;
		logic      mul;
		coef_sel_t coef;
		opnd_sel_t opnd;
		logic      acc_clr;
		logic      acc_add;
		logic      term;
		base_sel_t base;
		logic      term_sub;
		dst_sel_t  dst;
		logic      out_load;
	} cmd_t;

endpackage

[design/bqd_regs.sv]
`timescale 1ns / 1ps
// APB configuration registers: five coefficients and the bypass bit.
module bqd_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bqd_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [bqd_pkg::DATA_BITS-1:0]  pwdata,
	output logic [bqd_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready,
	output bqd_pkg::cfg_t                  cfg
);
	import bqd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.b0     <= COEF_ONE;
			cfg_q.b1     <= '0;
			cfg_q.b2     <= '0;
			cfg_q.a1     <= '0;
			cfg_q.a2     <= '0;
			cfg_q.bypass <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_B0:     cfg_q.b0     <= pwdata[COEF_BITS-1:0];
				REG_B1:     cfg_q.b1     <= pwdata[COEF_BITS-1:0];
				REG_B2:     cfg_q.b2     <= pwdata[COEF_BITS-1:0];
				REG_A1:     cfg_q.a1     <= pwdata[COEF_BITS-1:0];
				REG_A2:     cfg_q.a2     <= pwdata[COEF_BITS-1:0];
				REG_BYPASS: cfg_q.bypass <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_B0:     prdata = DATA_BITS'($unsigned(cfg_q.b0));
			REG_B1:     prdata = DATA_BITS'($unsigned(cfg_q.b1));
			REG_B2:     prdata = DATA_BITS'($unsigned(cfg_q.b2));
			REG_A1:     prdata = DATA_BITS'($unsigned(cfg_q.a1));
			REG_A2:     prdata = DATA_BITS'($unsigned(cfg_q.a2));
			REG_BYPASS: prdata = DATA_BITS'(cfg_q.bypass);
			default:    prdata = '0;
		endcase
	end

endmodule

[design/bqd_dp.sv]
`timescale 1ns / 1ps
// Datapath: shared 32x24 multiplier, rounding accumulator, state and output registers.
module bqd_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bqd_pkg::cmd_t                         cmd,
	input  bqd_pkg::cfg_t                         cfg,
	input  logic signed [bqd_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                  start_of_block,
	output logic signed [bqd_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic                                  clipped
);
	import bqd_pkg::*;

	localparam logic [WIDE_BITS-1:0] ROUND_TERM = WIDE_BITS'(1) << (COEF_FRAC_BITS - 1);
	localparam logic [ACC_BITS:0]    OUT_HALF   = (ACC_BITS+1)'(1) << (GUARD_BITS - 1);
	localparam int                   MAG_TOP    = COEF_FRAC_BITS + ACC_BITS - 1;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [SAMPLE_BITS-1:0]        x_mag_q;
	logic signed [ACC_BITS-1:0]    y_q;
	logic [ACC_BITS-1:0]           y_mag_q;
	logic signed [ACC_BITS-1:0]    s1_q;
	logic signed [ACC_BITS-1:0]    s2_q;
	logic signed [SUM_BITS-1:0]    sum_q;
	logic [PROD_BITS-1:0]          prod_q;
	opnd_sel_t                     prod_sel_q;
	logic                          prod_neg_q;
	logic [WIDE_BITS-1:0]          acc_q;
	logic                          acc_neg_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          clipped_q;

	logic signed [COEF_BITS-1:0]   coef_v;
	logic [COEF_BITS-1:0]          coef_mag;
	logic [CHUNK_BITS-1:0]         chunk;
	logic                          opnd_neg;
	logic [WIDE_BITS-1:0]          shifted;
	logic [ACC_BITS-2:0]           mag;
	logic                          term_neg;
	logic [SUM_BITS-1:0]           mag_e;
	logic signed [SUM_BITS-1:0]    base;
	logic signed [SUM_BITS-1:0]    sum_nx;
	logic signed [ACC_BITS-1:0]    sum_sat;
	logic [ACC_BITS:0]             rnd;
	logic                          out_ovf;

	// multiplier operands
	always_comb begin
		unique case (cmd.coef)
			CS_B0:   coef_v = cfg.b0;
			CS_B1:   coef_v = cfg.b1;
			CS_B2:   coef_v = cfg.b2;
			CS_A1:   coef_v = cfg.a1;
			CS_A2:   coef_v = cfg.a2;
			default: coef_v = '0;
		endcase
		coef_mag = coef_v[COEF_BITS-1] ? $unsigned(-coef_v) : $unsigned(coef_v);
		unique case (cmd.opnd)
			OP_X: begin
				chunk    = CHUNK_BITS'(x_mag_q);
				opnd_neg = x_q[SAMPLE_BITS-1];
			end
			OP_YLO: begin
				chunk    = y_mag_q[CHUNK_BITS-1:0];
				opnd_neg = y_q[ACC_BITS-1];
			end
			OP_YHI: begin
				chunk    = y_mag_q[ACC_BITS-1:CHUNK_BITS];
				opnd_neg = y_q[ACC_BITS-1];
			end
			default: begin
				chunk    = '0;
				opnd_neg = 1'b0;
			end
		endcase
	end

	// partial product alignment
	always_comb begin
		unique case (prod_sel_q)
			OP_X:    shifted = WIDE_BITS'(prod_q) << GUARD_BITS;
			OP_YLO:  shifted = WIDE_BITS'(prod_q);
			OP_YHI:  shifted = WIDE_BITS'(prod_q) << CHUNK_BITS;
			default: shifted = '0;
		endcase
	end

	// rounded, saturated term added to the selected base
	always_comb begin
		mag      = (|acc_q[WIDE_BITS-1:MAG_TOP]) ? ACC_MAX[ACC_BITS-2:0]
		                                           : acc_q[MAG_TOP-1:COEF_FRAC_BITS];
		term_neg = acc_neg_q ^ cmd.term_sub;
		mag_e    = SUM_BITS'(mag);
		unique case (cmd.base)
			BS_ZERO: base = '0;
			BS_S1:   base = SUM_BITS'(s1_q);
			BS_S2:   base = SUM_BITS'(s2_q);
			BS_SUM:  base = sum_q;
		endcase
		sum_nx = base + $signed(term_neg ? ~mag_e : mag_e) + $signed(SUM_BITS'(term_neg));
		if ((&sum_nx[SUM_BITS-1:ACC_BITS-1]) | ~(|sum_nx[SUM_BITS-1:ACC_BITS-1]))
			sum_sat = sum_nx[ACC_BITS-1:0];
		else
			sum_sat = sum_nx[SUM_BITS-1] ? ACC_MIN : ACC_MAX;
	end

	// output rounding, half up, then saturation
	always_comb begin
		rnd     = $unsigned({y_q[ACC_BITS-1], y_q}) + OUT_HALF;
		out_ovf = ~((&rnd[ACC_BITS:GUARD_BITS+SAMPLE_BITS-1]) |
		            ~(|rnd[ACC_BITS:GUARD_BITS+SAMPLE_BITS-1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
			s2_q <= '0;
		end else begin
			if (cmd.load && start_of_block) begin
				s1_q <= '0;
				s2_q <= '0;
			end else if (cmd.term) begin
				if (cmd.dst == DST_S1)
					s1_q <= sum_sat;
				if (cmd.dst == DST_S2)
					s2_q <= sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		y_mag_q <= y_q[ACC_BITS-1] ? $unsigned(-y_q) : $unsigned(y_q);
		if (cmd.load) begin
			x_q     <= sample_in;
			x_mag_q <= sample_in[SAMPLE_BITS-1] ? $unsigned(-sample_in) : $unsigned(sample_in);
		end
		if (cmd.mul) begin
			prod_q     <= PROD_BITS'(coef_mag) * PROD_BITS'(chunk);
			prod_sel_q <= cmd.opnd;
			prod_neg_q <= coef_v[COEF_BITS-1] ^ opnd_neg;
		end
		if (cmd.acc_clr) begin
			acc_q     <= ROUND_TERM + shifted;
			acc_neg_q <= prod_neg_q;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + shifted;
		end
		if (cmd.term) begin
			if (cmd.dst == DST_SUM)
				sum_q <= sum_nx;
			if (cmd.dst == DST_Y)
				y_q <= sum_sat;
		end
		if (cmd.out_load) begin
			if (cfg.bypass) begin
				sample_out_q <= x_q;
				clipped_q    <= 1'b0;
			end else if (out_ovf) begin
				sample_out_q <= rnd[ACC_BITS] ? SMP_MIN : SMP_MAX;
				clipped_q    <= 1'b1;
			end else begin
				sample_out_q <= rnd[GUARD_BITS+SAMPLE_BITS-1:GUARD_BITS];
				clipped_q    <= 1'b0;
			end
		end
	end

	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

endmodule

[design/bqd_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences the five products and the state updates for one sample.
module bqd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  logic          bypass,
	output bqd_pkg::cmd_t cmd
);
	import bqd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MB0,
		ST_AB0,
		ST_TY,
		ST_TB1,
		ST_MA1L,
		ST_MA1H,
		ST_AA1,
		ST_TS1,
		ST_TB2,
		ST_MA2H,
		ST_AA2,
		ST_TS2,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= bypass ? ST_DONE : ST_MB0;
				end
				ST_MB0:  state_q <= ST_AB0;
				ST_AB0:  state_q <= ST_TY;
				ST_TY:   state_q <= ST_TB1;
				ST_TB1:  state_q <= ST_MA1L;
				ST_MA1L: state_q <= ST_MA1H;
				ST_MA1H: state_q <= ST_AA1;
				ST_AA1:  state_q <= ST_TS1;
				ST_TS1:  state_q <= ST_TB2;
				ST_TB2:  state_q <= ST_MA2H;
				ST_MA2H: state_q <= ST_AA2;
				ST_AA2:  state_q <= ST_TS2;
				ST_TS2:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_MB0: begin
				cmd.mul  = 1'b1;
				cmd.coef = CS_B0;
				cmd.opnd = OP_X;
			end
			ST_AB0: begin
				cmd.acc_clr = 1'b1;
				cmd.mul     = 1'b1;
				cmd.coef    = CS_B1;
				cmd.opnd    = OP_X;
			end
			ST_TY: begin
				cmd.term    = 1'b1;
				cmd.base    = BS_S1;
				cmd.dst     = DST_Y;
				cmd.acc_clr = 1'b1;
			end
			ST_TB1: begin
				cmd.term = 1'b1;
				cmd.base = BS_S2;
				cmd.dst  = DST_SUM;
			end
			ST_MA1L: begin
				cmd.mul  = 1'b1;
				cmd.coef = CS_A1;
				cmd.opnd = OP_YLO;
			end
			ST_MA1H: begin
				cmd.mul     = 1'b1;
				cmd.coef    = CS_A1;
				cmd.opnd    = OP_YHI;
				cmd.acc_clr = 1'b1;
			end
			ST_AA1: begin
				cmd.acc_add = 1'b1;
				cmd.mul     = 1'b1;
				cmd.coef    = CS_B2;
				cmd.opnd    = OP_X;
			end
			ST_TS1: begin
				cmd.term     = 1'b1;
				cmd.base     = BS_SUM;
				cmd.term_sub = 1'b1;
				cmd.dst      = DST_S1;
				cmd.acc_clr  = 1'b1;
			end
			ST_TB2: begin
				cmd.term = 1'b1;
				cmd.base = BS_ZERO;
				cmd.dst  = DST_SUM;
				cmd.mul  = 1'b1;
				cmd.coef = CS_A2;
				cmd.opnd = OP_YLO;
			end
			ST_MA2H: begin
				cmd.mul     = 1'b1;
				cmd.coef    = CS_A2;
				cmd.opnd    = OP_YHI;
				cmd.acc_clr = 1'b1;
			end
			ST_AA2: cmd.acc_add = 1'b1;
			ST_TS2: begin
				cmd.term     = 1'b1;
				cmd.base     = BS_SUM;
				cmd.term_sub = 1'b1;
				cmd.dst      = DST_S2;
			end
			ST_DONE: cmd.out_load = out_free;
			default: ;
		endcase
	end

endmodule

[design/biquad_iir_filter_unit.sv]
`timescale 1ns / 1ps
// Top level: biquad IIR section, transposed direct form II, with APB configuration.
// Each sample takes seven passes through the single shared 32x24 multiplier and its one
// accumulator (none in bypass); a new sample is taken only after the last one is in the
// output register, and an output stall holds the filter until that register is free.
// Reset: coefficients return to b0 = 1.0, others 0, bypass off; both filter
// states clear; no output is pending.
module biquad_iir_filter_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [bqd_pkg::ADDR_BITS-1:0]         paddr,
	input  logic [bqd_pkg::DATA_BITS-1:0]         pwdata,
	output logic [bqd_pkg::DATA_BITS-1:0]         prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [bqd_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                  start_of_block,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [bqd_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic                                  clipped
);
	import bqd_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	bqd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bqd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bypass    (cfg.bypass),
		.cmd       (cmd)
	);

	bqd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg),
		.sample_in      (sample_in),
		.start_of_block (start_of_block),
		.sample_out     (sample_out),
		.clipped        (clipped)
	);

endmodule
